### rtl/pgsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgsm_pkg: shared definitions for the prefix group same-member check
// Field widths, table sizes, request kinds and the coverage result type.
// ----------------------------------------------------------------------------
package pgsm_pkg;

    localparam int ENTITY_COUNT     = 1024;
    localparam int SLOTS_PER_ENTITY = 16;

    localparam int ENT_W  = 10;
    localparam int CNT_W  = 5;
    localparam int SLOT_W = 4;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;

    localparam int PFX_DEPTH  = ENTITY_COUNT * SLOTS_PER_ENTITY;
    localparam int PFX_DATA_W = LEN_W + ADDR_W;
    localparam int ENT_DATA_W = CNT_W + 1;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } pgsm_hit_t;

endpackage
`default_nettype wire

### rtl/pgsm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgsm_ram: single-port RAM with registered read data
// One write or one read per cycle; read data is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
module pgsm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [AddrW-1:0]  addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### rtl/pgsm_cover.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgsm_cover: prefix coverage compare unit
// Checks one stored prefix against both queried addresses under one mask.
// ----------------------------------------------------------------------------
module pgsm_cover (
    input  wire logic [pgsm_pkg::ADDR_W-1:0] base,
    input  wire logic [pgsm_pkg::LEN_W-1:0]  len,
    input  wire logic [pgsm_pkg::ADDR_W-1:0] addr_a,
    input  wire logic [pgsm_pkg::ADDR_W-1:0] addr_b,
    output pgsm_pkg::pgsm_hit_t              hit
);
    import pgsm_pkg::*;

    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  shamt;
    logic [ADDR_W-1:0] mask;

    always_comb begin
        len_sat   = (len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len;
        shamt     = LEN_W'(ADDR_W) - len_sat;
        mask      = {ADDR_W{1'b1}} << shamt;
        hit.hit_a = ((base ^ addr_a) & mask) == '0;
        hit.hit_b = ((base ^ addr_b) & mask) == '0;
    end

endmodule
`default_nettype wire

### rtl/prefix_group_same_member_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_group_same_member_check: live entity prefix groups and pair query
// Begin, store and delete requests are written in the cycle they are accepted.
// A query walks the entities (ST_ENT_RD, ST_ENT_CHK, one ST_SLOT step per slot
// of a live entity, ST_ENT_END) and stops early once one entity covers both
// addresses; s_tready stays low until ST_DONE loads the answer, longer while
// the answer is held. The single prefix RAM read port sets the pace of one slot
// per cycle. After reset ST_CLEAR clears the entity table; s_tready is low.
// ----------------------------------------------------------------------------
module prefix_group_same_member_check (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // entity_id, prefix_count, slot, address_a, prefix_len, address_b, zeros
    input  wire logic [pgsm_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  wire logic [pgsm_pkg::KIND_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // same_member, zeros
    output logic      [pgsm_pkg::M_DATA_W-1:0]   m_tdata
);
    import pgsm_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ENT_RD  = 3'd2;
    localparam logic [2:0] ST_ENT_CHK = 3'd3;
    localparam logic [2:0] ST_SLOT    = 3'd4;
    localparam logic [2:0] ST_ENT_END = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(ENTITY_COUNT - 1);

    logic [ENT_W-1:0]  s_ent;
    logic [CNT_W-1:0]  s_cnt;
    logic [SLOT_W-1:0] s_slot;
    logic [ADDR_W-1:0] s_addr_a;
    logic [LEN_W-1:0]  s_plen;
    logic [ADDR_W-1:0] s_addr_b;
    logic [CNT_W-1:0]  s_cnt_sat;

    assign s_ent    = s_tdata[9:0];
    assign s_cnt    = s_tdata[14:10];
    assign s_slot   = s_tdata[18:15];
    assign s_addr_a = s_tdata[50:19];
    assign s_plen   = s_tdata[56:51];
    assign s_addr_b = s_tdata[88:57];
    assign s_cnt_sat = (s_cnt > CNT_W'(SLOTS_PER_ENTITY)) ? CNT_W'(SLOTS_PER_ENTITY) : s_cnt;

    logic [2:0]        state_reg,   state_next;
    logic [ENT_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [ENT_W-1:0]  ent_idx_reg, ent_idx_next;
    logic [SLOT_W-1:0] slot_reg,    slot_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              fa_reg,      fa_next;
    logic              fb_reg,      fb_next;
    logic              result_reg,  result_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_data_reg,  m_data_next;
    logic [ADDR_W-1:0] addr_a_reg,  addr_a_next;
    logic [ADDR_W-1:0] addr_b_reg,  addr_b_next;

    logic                     ent_we;
    logic [ENT_W-1:0]         ent_addr;
    logic [ENT_DATA_W-1:0]    ent_wdata;
    logic [ENT_DATA_W-1:0]    ent_rdata;
    logic                     pfx_we;
    logic [ENT_W+SLOT_W-1:0]  pfx_addr;
    logic [PFX_DATA_W-1:0]    pfx_wdata;
    logic [PFX_DATA_W-1:0]    pfx_rdata;
    pgsm_hit_t                hit;

    pgsm_ram #(
        .DATA_W (ENT_DATA_W),
        .DEPTH  (ENTITY_COUNT)
    ) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (ent_wdata),
        .rdata (ent_rdata)
    );

    pgsm_ram #(
        .DATA_W (PFX_DATA_W),
        .DEPTH  (PFX_DEPTH)
    ) u_pfx_ram (
        .aclk  (aclk),
        .we    (pfx_we),
        .addr  (pfx_addr),
        .wdata (pfx_wdata),
        .rdata (pfx_rdata)
    );

    pgsm_cover u_cover (
        .base   (pfx_rdata[ADDR_W-1:0]),
        .len    (pfx_rdata[PFX_DATA_W-1:ADDR_W]),
        .addr_a (addr_a_reg),
        .addr_b (addr_b_reg),
        .hit    (hit)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, m_data_reg};

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        ent_idx_next = ent_idx_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        addr_a_next  = addr_a_reg;
        addr_b_next  = addr_b_reg;
        ent_we       = 1'b0;
        ent_addr     = ent_idx_reg;
        ent_wdata    = '0;
        pfx_we       = 1'b0;
        pfx_addr     = {ent_idx_reg, slot_reg};
        pfx_wdata    = {s_plen, s_addr_a};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ent_we   = 1'b1;
                ent_addr = clr_idx_reg;
                if (clr_idx_reg == ENT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + ENT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        KIND_BEGIN: begin
                            ent_we    = 1'b1;
                            ent_addr  = s_ent;
                            ent_wdata = {1'b1, s_cnt_sat};
                        end
                        KIND_STORE: begin
                            pfx_we   = 1'b1;
                            pfx_addr = {s_ent, s_slot};
                        end
                        KIND_DELETE: begin
                            ent_we   = 1'b1;
                            ent_addr = s_ent;
                        end
                        KIND_QUERY: begin
                            addr_a_next  = s_addr_a;
                            addr_b_next  = s_addr_b;
                            ent_idx_next = '0;
                            state_next   = ST_ENT_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENT_RD: begin
                state_next = ST_ENT_CHK;
            end
            ST_ENT_CHK: begin
                fa_next = 1'b0;
                fb_next = 1'b0;
                if (ent_rdata[CNT_W] && (ent_rdata[CNT_W-1:0] != '0)) begin
                    cnt_next   = ent_rdata[CNT_W-1:0];
                    slot_next  = '0;
                    pfx_addr   = {ent_idx_reg, {SLOT_W{1'b0}}};
                    state_next = ST_SLOT;
                end else begin
                    state_next = ST_ENT_END;
                end
            end
            ST_SLOT: begin
                fa_next = fa_reg | hit.hit_a;
                fb_next = fb_reg | hit.hit_b;
                if ((CNT_W'(slot_reg) + CNT_W'(1)) == cnt_reg) begin
                    state_next = ST_ENT_END;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                    pfx_addr  = {ent_idx_reg, slot_reg + SLOT_W'(1)};
                end
            end
            ST_ENT_END: begin
                if (fa_reg && fb_reg) begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end else if (ent_idx_reg == ENT_LAST) begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    ent_idx_next = ent_idx_reg + ENT_W'(1);
                    state_next   = ST_ENT_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_idx_reg <= ent_idx_next;
        slot_reg    <= slot_next;
        cnt_reg     <= cnt_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        result_reg  <= result_next;
        m_data_reg  <= m_data_next;
        addr_a_reg  <= addr_a_next;
        addr_b_reg  <= addr_b_next;
    end

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == ST_CLEAR) && !s_tready && !m_tvalid)
        else $error("reset did not start the table clear");

    a_slot_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOT) |-> (cnt_reg != '0) && (CNT_W'(slot_reg) < cnt_reg))
        else $error("slot walk beyond entity count");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_QUERY))
        |=> (state_reg == ST_ENT_RD) && (ent_idx_reg == '0))
        else $error("query did not start at first entity");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && (!m_valid_reg || m_tready))
        |=> m_tvalid && (m_tdata[0] == $past(result_reg)))
        else $error("query result not presented");
`endif

endmodule
`default_nettype wire
